FILE: rtl/mtws_pkg.sv
// Shared types and constants of the untempered Mersenne Twister step core.
`timescale 1ns / 1ps
`default_nettype none

package mtws_pkg;

  // Defaults of the top-level parameters.
  localparam int MTWS_MAX_WORDS = 1024;
  localparam int MTWS_OUT_BITS  = 32;

  // Field widths of the streaming and configuration ports.
  localparam int WORD_BITS_W   = 6;
  localparam int WORD_COUNT_W  = 11;
  localparam int MIDDLE_W      = 10;
  localparam int SPLIT_W       = 5;
  localparam int DATA_W        = 32;
  localparam int INDEX_W       = 10;
  localparam int IN_TDATA_W    = 48;
  localparam int CFG_INDEX_W   = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_BITS       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_COUNT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIDDLE_DISTANCE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_BITS      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TWIST_COEFF     = 3'd4;

  // Register reset values.
  localparam logic [WORD_BITS_W-1:0]  RST_WORD_BITS   = 6'd32;
  localparam logic [WORD_COUNT_W-1:0] RST_WORD_COUNT  = 11'd624;
  localparam logic [MIDDLE_W-1:0]     RST_MIDDLE      = 10'd397;
  localparam logic [SPLIT_W-1:0]      RST_SPLIT_BITS  = 5'd31;
  localparam logic [DATA_W-1:0]       RST_TWIST_COEFF = 32'h9908_B0DF;

  // Input command codes carried on tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_RD_MID,
    ST_TWIST,
    ST_WIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/mtws_ring.sv
// State ring memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mtws_ring #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [mtws_pkg::DATA_W-1:0]  wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [mtws_pkg::DATA_W-1:0]  rdata
);
  import mtws_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/mersenne_twister_step_core.sv
// Top level of the untempered Mersenne Twister step core with its sequencer.
`timescale 1ns / 1ps
`default_nettype none

// A load word produces no output and leaves the core idle, so it is ready again for the next word.
// A step word reduces the position and middle distance modulo r by repeated subtraction
// (none in normal use), reads the current, next and middle words, writes back the twisted
// word and then reads window words, one per cycle, until OUT_BITS bits are gathered.
// Throughput is one word at a time; the result waits in an output register.
// Reset (rst, synchronous) clears the position, the sequencer and the output valid, and loads
// the register defaults; the state memory is not cleared and must be loaded before use.
module mersenne_twister_step_core #(
  parameter int MAX_WORDS = mtws_pkg::MTWS_MAX_WORDS,
  parameter int OUT_BITS  = mtws_pkg::MTWS_OUT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [mtws_pkg::IN_TDATA_W-1:0]   s_tdata,  // word_index[9:0], word_value[41:10]
  input  wire logic                              s_tuser,  // command
  // Output stream.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [mtws_pkg::DATA_W-1:0]       m_tdata,  // random_bits[31:0]
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mtws_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mtws_pkg::DATA_W-1:0]       cfg_data
);
  import mtws_pkg::*;

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int RW = (CW > MIDDLE_W) ? CW : MIDDLE_W;
  localparam int SW = RW + 1;
  localparam logic [DATA_W-1:0] OUT_MASK = ~(32'hFFFF_FFFF >> OUT_BITS);

  // Configuration registers.
  logic [WORD_BITS_W-1:0]  word_bits;
  logic [WORD_COUNT_W-1:0] word_count;
  logic [MIDDLE_W-1:0]     middle_distance;
  logic [SPLIT_W-1:0]      split_bits;
  logic [DATA_W-1:0]       twist_coeff;

  // Sequencer and datapath registers.
  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     position;
  logic [RW-1:0]     pos_red;
  logic [RW-1:0]     m_red;
  logic [AW-1:0]     nxt_idx;
  logic [AW-1:0]     mid_idx;
  logic [AW-1:0]     win_idx;
  logic [DATA_W-1:0] y_reg;
  logic [DATA_W-1:0] acc;
  logic [6:0]        have;
  logic              pend;

  // Input fields.
  logic [INDEX_W-1:0] word_index;
  logic [DATA_W-1:0]  word_value;
  logic               s_accept;

  // Effective configuration and masks.
  logic [5:0]        w_eff;
  logic [CW-1:0]     r_eff;
  logic [RW-1:0]     r_ext;
  logic [AW-1:0]     r_last;
  logic [DATA_W-1:0] wmask;
  logic [DATA_W-1:0] low_mask;
  logic [DATA_W-1:0] up_mask;

  // Shared compare-and-subtract unit for the modulo reductions.
  logic              pos_high;
  logic              mid_high;
  logic [RW-1:0]     sub_res;

  // Index arithmetic.
  logic [AW-1:0]     cur_idx;
  logic [SW-1:0]     nxt_sum;
  logic [SW-1:0]     mid_sum;
  logic [SW-1:0]     mid_full;
  logic [AW-1:0]     nxt_calc;
  logic [AW-1:0]     mid_calc;
  logic [AW-1:0]     win_dec;

  // Twist and window placement.
  logic [DATA_W-1:0] twist_word;
  logic [6:0]        rem;
  logic [6:0]        have_sum;
  logic [DATA_W-1:0] placed;

  // Memory port.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_q;
  logic              load_ok;

  assign word_index = s_tdata[INDEX_W-1:0];
  assign word_value = s_tdata[INDEX_W+DATA_W-1:INDEX_W];
  assign s_tready   = (state == ST_IDLE);
  assign s_accept   = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;

  // Out-of-range width and count registers act as the nearest legal value.
  always_comb begin
    if (word_bits < 6'd2) begin
      w_eff = 6'd2;
    end else if (word_bits > 6'd32) begin
      w_eff = 6'd32;
    end else begin
      w_eff = word_bits;
    end
    if (word_count < 11'd2) begin
      r_eff = CW'(2);
    end else if (32'(word_count) > 32'(MAX_WORDS)) begin
      r_eff = CW'(MAX_WORDS);
    end else begin
      r_eff = CW'(word_count);
    end
  end

  assign r_ext    = RW'(r_eff);
  assign r_last   = AW'(r_eff - CW'(1));
  assign wmask    = 32'hFFFF_FFFF >> (6'd32 - w_eff);
  assign low_mask = ~(32'hFFFF_FFFF << split_bits);
  assign up_mask  = (wmask << split_bits) & wmask;
  assign load_ok  = (RW'(word_index) < r_ext);

  // The position is reduced first, then the middle distance, through one subtractor.
  assign pos_high = (pos_red >= r_ext);
  assign mid_high = (m_red >= r_ext);
  assign sub_res  = (pos_high ? pos_red : m_red) - r_ext;

  assign cur_idx  = pos_red[AW-1:0];
  assign nxt_sum  = SW'(cur_idx) + SW'(1);
  assign nxt_calc = (nxt_sum >= SW'(r_eff)) ? '0 : nxt_sum[AW-1:0];
  assign mid_sum  = SW'(cur_idx) + SW'(m_red);
  assign mid_full = (mid_sum >= SW'(r_eff)) ? (mid_sum - SW'(r_eff)) : mid_sum;
  assign mid_calc = mid_full[AW-1:0];
  assign win_dec  = (win_idx == '0) ? r_last : (win_idx - AW'(1));

  // In the twist cycle the memory returns the middle word.
  assign twist_word = (mem_q ^ (y_reg >> 1) ^ (y_reg[0] ? twist_coeff : '0)) & wmask;

  // The window fills from bit 31 downward; a word that crosses the bottom of the
  // free space is cut to its leading bits.
  assign rem      = 7'd32 - have;
  assign have_sum = have + 7'(w_eff);
  assign placed   = (7'(w_eff) <= rem) ? (mem_q << 5'(rem - 7'(w_eff)))
                                       : (mem_q >> 5'(7'(w_eff) - rem));

  mtws_ring #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_accept && (s_tuser == CMD_STEP)) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!pos_high && !mid_high) begin
          state_next = ST_RD_CUR;
        end
      end
      ST_RD_CUR: state_next = ST_RD_NXT;
      ST_RD_NXT: state_next = ST_RD_MID;
      ST_RD_MID: state_next = ST_TWIST;
      ST_TWIST:  state_next = ST_WIN;
      ST_WIN: begin
        if (pend && (have_sum >= 7'(OUT_BITS))) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_idx;
    mem_wdata = twist_word;
    mem_raddr = cur_idx;
    unique case (state)
      ST_IDLE: begin
        mem_we    = s_accept && (s_tuser == CMD_LOAD) && load_ok;
        mem_waddr = AW'(word_index);
        mem_wdata = word_value & wmask;
      end
      ST_RD_NXT: mem_raddr = nxt_idx;
      ST_RD_MID: mem_raddr = mid_idx;
      ST_TWIST:  mem_we = 1'b1;
      ST_WIN:    mem_raddr = win_idx;
      ST_REDUCE, ST_RD_CUR, ST_EMIT: begin
        mem_raddr = cur_idx;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_bits       <= RST_WORD_BITS;
      word_count      <= RST_WORD_COUNT;
      middle_distance <= RST_MIDDLE;
      split_bits      <= RST_SPLIT_BITS;
      twist_coeff     <= RST_TWIST_COEFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WORD_BITS:       word_bits       <= cfg_data[WORD_BITS_W-1:0];
        CFG_WORD_COUNT:      word_count      <= cfg_data[WORD_COUNT_W-1:0];
        CFG_MIDDLE_DISTANCE: middle_distance <= cfg_data[MIDDLE_W-1:0];
        CFG_SPLIT_BITS:      split_bits      <= cfg_data[SPLIT_W-1:0];
        CFG_TWIST_COEFF:     twist_coeff     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      position <= '0;
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept && (s_tuser == CMD_LOAD)) begin
            position <= '0;
          end
        end
        ST_TWIST: pend <= 1'b0;
        ST_WIN:   pend <= 1'b1;
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            position <= nxt_idx;
          end
        end
        ST_REDUCE, ST_RD_CUR, ST_RD_NXT, ST_RD_MID: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pos_red <= RW'(position);
        m_red   <= RW'(middle_distance);
      end
      ST_REDUCE: begin
        if (pos_high) begin
          pos_red <= sub_res;
        end else if (mid_high) begin
          m_red <= sub_res;
        end
      end
      ST_RD_CUR: begin
        nxt_idx <= nxt_calc;
        mid_idx <= mid_calc;
      end
      ST_RD_NXT: y_reg <= mem_q & up_mask;
      ST_RD_MID: y_reg <= y_reg | (mem_q & low_mask);
      ST_TWIST: begin
        win_idx <= cur_idx;
        acc     <= '0;
        have    <= '0;
      end
      ST_WIN: begin
        win_idx <= win_dec;
        if (pend) begin
          acc  <= acc | placed;
          have <= have_sum;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= acc & OUT_MASK;
        end
      end
    endcase
  end

  // A result appears only from the emit state.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_EMIT))
    else $error("output valid rose outside the emit state");

  // A load word always returns the position to zero.
  a_load_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == CMD_LOAD)) |=> (position == '0))
    else $error("position not cleared by a load word");

  // Reduced position and middle distance are in range once the reads start.
  a_reduced_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_CUR) |-> ((pos_red < r_ext) && (m_red < r_ext)))
    else $error("modulo reduction left an index out of range");

  // The window is still short of OUT_BITS while it is being filled.
  a_window_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WIN) |-> (have < 7'(OUT_BITS)))
    else $error("window fill overran the output width");

endmodule

`default_nettype wire
